>>> src/vlp_pkg.sv
`timescale 1ns / 1ps

package vlp_pkg;

   localparam int unsigned VOXEL_COUNT = 65536;
   localparam int unsigned VOX_ADDR_W  = $clog2(VOXEL_COUNT);

   localparam int unsigned INDEX_W  = 16;
   localparam int unsigned LENGTH_W = 24;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned ACC_W    = 48;

   localparam int unsigned REQ_DATA_W = 104;
   localparam int unsigned RSP_DATA_W = 56;

   typedef enum logic [1:0] {
      REQ_WRITE   = 2'd0,
      REQ_FORWARD = 2'd1,
      REQ_BACK    = 2'd2,
      REQ_READ    = 2'd3
   } req_kind_type;

   localparam logic RESULT_INTEGRAL = 1'b0;
   localparam logic RESULT_VOXEL    = 1'b1;

   // One decoded request word as it waits between front and back.
   typedef struct packed {
      req_kind_type           kind;
      logic [INDEX_W-1:0]     index;
      logic                   index_ok;
      logic [LENGTH_W-1:0]    seg_length;
      logic [VALUE_W-1:0]     operand;
      logic                   last;
   } cmd_type;

endpackage

>>> src/vlp_ram.sv
`timescale 1ns / 1ps

module vlp_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/vlp_front.sv
`timescale 1ns / 1ps

module vlp_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [vlp_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [1:0]                         req_tuser,
   input  logic                               req_tlast,
   output logic                               head_valid,
   output vlp_pkg::cmd_type                   head,
   input  logic                               head_pop
);

   vlp_pkg::cmd_type slot_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   vlp_pkg::cmd_type cmd_in;
   logic             push;
   logic             pop;
   logic [31:0]      index_wide;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != 2'd0);
   assign pop        = head_pop && head_valid;
   assign head       = slot_ff[rd_ptr_ff];

   assign index_wide = {16'b0, req_tdata[15:0]};

   // Writes carry their data as the operand, backprojections the line value.
   always_comb begin
      cmd_in.kind       = vlp_pkg::req_kind_type'(req_tuser);
      cmd_in.index      = req_tdata[15:0];
      cmd_in.index_ok   = (index_wide < 32'(vlp_pkg::VOXEL_COUNT));
      cmd_in.seg_length = req_tdata[39:16];
      cmd_in.operand    = (cmd_in.kind == vlp_pkg::REQ_WRITE) ? req_tdata[103:72]
                                                               : req_tdata[71:40];
      cmd_in.last       = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

>>> src/vlp_back.sv
`timescale 1ns / 1ps

module vlp_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               head_valid,
   input  vlp_pkg::cmd_type                   head,
   output logic                               head_pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [vlp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MUL,
      S_ACC,
      S_VOXOUT
   } state_type;

   localparam logic [vlp_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(vlp_pkg::ACC_W-1){1'b1}}};
   localparam logic [vlp_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(vlp_pkg::ACC_W-1){1'b0}}};
   localparam logic [vlp_pkg::VALUE_W-1:0] VOX_MAX = {1'b0, {(vlp_pkg::VALUE_W-1){1'b1}}};
   localparam logic [vlp_pkg::VALUE_W-1:0] VOX_MIN = {1'b1, {(vlp_pkg::VALUE_W-1){1'b0}}};

   state_type                      state_ff;
   vlp_pkg::cmd_type               cmd_ff;
   logic signed [56:0]             prod_ff;
   logic signed [56:0]             prod_in;
   logic [vlp_pkg::ACC_W-1:0]      acc_ff;
   logic                           clipped_ff;
   logic                           out_valid_ff;
   logic                           out_kind_ff;
   logic [vlp_pkg::ACC_W-1:0]      out_value_ff;
   logic                           out_sat_ff;

   logic                           ram_wr_en;
   logic [vlp_pkg::VOX_ADDR_W-1:0] ram_wr_addr;
   logic [vlp_pkg::VALUE_W-1:0]    ram_wr_data;
   logic                           ram_rd_en;
   logic [vlp_pkg::VALUE_W-1:0]    ram_rd_data;

   logic [vlp_pkg::VALUE_W-1:0]    mul_op;
   logic signed [40:0]             scaled;
   logic signed [48:0]             acc_sum;
   logic [vlp_pkg::ACC_W-1:0]      acc_clamped;
   logic                           acc_clip;
   logic signed [41:0]             vox_sum;
   logic [vlp_pkg::VALUE_W-1:0]    vox_clamped;
   logic                           out_free;
   logic                           out_load;
   logic                           pop_write;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign head_pop  = (state_ff == S_IDLE) && head_valid;
   assign pop_write = head_pop && (head.kind == vlp_pkg::REQ_WRITE);
   assign ram_rd_en = (state_ff == S_READ);

   // A new result word enters the output register in this cycle.
   assign out_load = out_free
                   && ((state_ff == S_VOXOUT)
                       || ((state_ff == S_ACC) && (cmd_ff.kind == vlp_pkg::REQ_FORWARD)
                           && cmd_ff.last));

   // The store has one write port: direct writes as they leave the queue,
   // backprojection updates at the end of their read-modify-write.
   always_comb begin
      if (state_ff == S_ACC) begin
         ram_wr_en   = (cmd_ff.kind == vlp_pkg::REQ_BACK) && cmd_ff.index_ok;
         ram_wr_addr = vlp_pkg::VOX_ADDR_W'(cmd_ff.index);
         ram_wr_data = vox_clamped;
      end else begin
         ram_wr_en   = pop_write && head.index_ok;
         ram_wr_addr = vlp_pkg::VOX_ADDR_W'(head.index);
         ram_wr_data = head.operand;
      end
   end

   vlp_ram #(
      .WIDTH (vlp_pkg::VALUE_W),
      .DEPTH (vlp_pkg::VOXEL_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (vlp_pkg::VOX_ADDR_W'(cmd_ff.index)),
      .rd_data (ram_rd_data)
   );

   // Q8.16 length times Q16.16 value; the arithmetic shift by 16 floors.
   assign mul_op  = (cmd_ff.kind == vlp_pkg::REQ_FORWARD) ? ram_rd_data : cmd_ff.operand;
   assign prod_in = 57'($signed({1'b0, cmd_ff.seg_length}) * $signed(mul_op));

   always_comb begin
      scaled = prod_ff[56:16];
      if (!cmd_ff.index_ok) begin
         scaled = '0;
      end
      acc_sum  = $signed({acc_ff[vlp_pkg::ACC_W-1], acc_ff})
               + $signed({{8{scaled[40]}}, scaled});
      acc_clip = (acc_sum[48] != acc_sum[47]);
      if (acc_clip) begin
         acc_clamped = acc_sum[48] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_clamped = acc_sum[47:0];
      end
      vox_sum = $signed({{10{ram_rd_data[31]}}, ram_rd_data}) + $signed({scaled[40], scaled});
      if ((vox_sum[41:31] == 11'h000) || (vox_sum[41:31] == 11'h7FF)) begin
         vox_clamped = vox_sum[31:0];
      end else begin
         vox_clamped = vox_sum[41] ? VOX_MIN : VOX_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         cmd_ff <= head;
      end
      if (state_ff == S_MUL) begin
         prod_ff <= prod_in;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         clipped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         out_kind_ff  <= vlp_pkg::RESULT_INTEGRAL;
         out_value_ff <= '0;
         out_sat_ff   <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_tready && !out_load) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (head_pop && !pop_write) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= (cmd_ff.kind == vlp_pkg::REQ_READ) ? S_VOXOUT : S_MUL;
            end
            S_MUL: begin
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (cmd_ff.kind != vlp_pkg::REQ_FORWARD) begin
                  state_ff <= S_IDLE;
               end else if (!cmd_ff.last) begin
                  acc_ff     <= acc_clamped;
                  clipped_ff <= clipped_ff | acc_clip;
                  state_ff   <= S_IDLE;
               end else if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_kind_ff  <= vlp_pkg::RESULT_INTEGRAL;
                  out_value_ff <= acc_clamped;
                  out_sat_ff   <= clipped_ff | acc_clip;
                  acc_ff       <= '0;
                  clipped_ff   <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            S_VOXOUT: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_kind_ff  <= vlp_pkg::RESULT_VOXEL;
                  out_value_ff <= cmd_ff.index_ok
                                  ? {{16{ram_rd_data[31]}}, ram_rd_data} : '0;
                  out_sat_ff   <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {7'b0, out_sat_ff, out_value_ff};

endmodule

>>> src/voxel_line_projector.sv
`timescale 1ns / 1ps
// In the back end a voxel write is done as it leaves the queue, a voxel read passes the
// read and voxel-out states, and a forward or backprojection element the read, multiply
// and accumulate or write-back states (the voxel store has one read and one write port).
// Read results and path integrals are registered. A two-word queue parts the input from
// the back end. Synchronous reset clears the queue, the accumulator and the output
// register; the store is undefined until written.

module voxel_line_projector (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // voxel_index[15:0], seg_length[39:16], line_value[71:40], write_data[103:72]
   input  logic [vlp_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]                     req_tuser,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // result_value[47:0], saturated[48], zero fill[55:49]
   output logic [vlp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // result_kind[0]
   output logic                           rsp_tuser
);

   logic             head_valid;
   logic             head_pop;
   vlp_pkg::cmd_type head;

   vlp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop)
   );

   vlp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
